### design/obj_face_vertex_dedup_fan_macros.svh
// Assertion macros shared by the vertex dedup block.
`ifndef OBJ_FACE_VERTEX_DEDUP_FAN_MACROS_SVH
`define OBJ_FACE_VERTEX_DEDUP_FAN_MACROS_SVH
`ifndef SYNTHESIS
`define OFVD_CHECK(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("check failed");
`define OFVD_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication failed");
`define OFVD_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define OFVD_CHECK(lbl, expr)
`define OFVD_IMPLY(lbl, ante, cons)
`define OFVD_NEXT(lbl, ante, cons)
`endif
`endif

### design/ofvd_pkg.sv
// Shared types and constants of the vertex dedup block.
package ofvd_pkg;
	localparam int VTD = 4096;
	localparam int AW = $clog2(VTD);
	localparam int CW = AW + 1;
	localparam int IDX_W = 12;
	localparam int IN_W = 152;
	localparam int OUT_W = 128;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_EMIT_V,
		ST_EMIT_T,
		ST_EMIT_E
	} state_t;

	typedef enum logic [1:0] {
		KIND_VERTEX = 2'd0,
		KIND_TRI = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE = 3'd0,
		ERR_POSITION = 3'd1,
		ERR_ATTRIBUTE = 3'd2,
		ERR_SHORT_FACE = 3'd3,
		ERR_TABLE_FULL = 3'd4
	} err_t;

	typedef struct packed {
		logic load_in;
		logic scan_start;
		logic scan_run;
		logic commit;
		logic out_load;
		kind_t kind;
		err_t err;
		logic out_last;
		logic set_failed;
	} cmd_t;

	typedef struct packed {
		logic failed;
		logic bad_pos;
		logic bad_attr;
		logic hit;
		logic miss;
		logic full;
		logic [1:0] corners;
		logic last_in;
		logic out_free;
	} sts_t;
endpackage

### design/ofvd_ctrl.sv
// Controller state machine of the vertex dedup block.
module ofvd_ctrl (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input ofvd_pkg::sts_t sts,
	output ofvd_pkg::cmd_t cmd
);
	ofvd_pkg::state_t state_q, state_d;
	ofvd_pkg::err_t err_q, err_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ofvd_pkg::ST_IDLE;
			err_q <= ofvd_pkg::ERR_NONE;
		end else begin
			state_q <= state_d;
			err_q <= err_d;
		end
	end

	always_comb begin
		state_d = state_q;
		err_d = err_q;
		cmd = '0;
		cmd.kind = ofvd_pkg::KIND_VERTEX;
		cmd.err = ofvd_pkg::ERR_NONE;
		s_tready = 1'b0;
		unique case (state_q)
			ofvd_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && !sts.failed) begin
					cmd.load_in = 1'b1;
					state_d = ofvd_pkg::ST_CHECK;
				end
			end
			ofvd_pkg::ST_CHECK: begin
				if (sts.bad_pos) begin
					err_d = ofvd_pkg::ERR_POSITION;
					state_d = ofvd_pkg::ST_EMIT_E;
				end else if (sts.bad_attr) begin
					err_d = ofvd_pkg::ERR_ATTRIBUTE;
					state_d = ofvd_pkg::ST_EMIT_E;
				end else begin
					cmd.scan_start = 1'b1;
					state_d = ofvd_pkg::ST_SCAN;
				end
			end
			ofvd_pkg::ST_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.hit) begin
					state_d = ofvd_pkg::ST_EMIT_V;
				end else if (sts.miss) begin
					if (sts.full) begin
						err_d = ofvd_pkg::ERR_TABLE_FULL;
						state_d = ofvd_pkg::ST_EMIT_E;
					end else begin
						state_d = ofvd_pkg::ST_EMIT_V;
					end
				end
			end
			ofvd_pkg::ST_EMIT_V: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.commit = 1'b1;
					cmd.kind = ofvd_pkg::KIND_VERTEX;
					if (sts.corners == 2'd2) begin
						state_d = ofvd_pkg::ST_EMIT_T;
					end else if (sts.last_in) begin
						err_d = ofvd_pkg::ERR_SHORT_FACE;
						state_d = ofvd_pkg::ST_EMIT_E;
					end else begin
						cmd.out_last = 1'b1;
						state_d = ofvd_pkg::ST_IDLE;
					end
				end
			end
			ofvd_pkg::ST_EMIT_T: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.kind = ofvd_pkg::KIND_TRI;
					cmd.out_last = 1'b1;
					state_d = ofvd_pkg::ST_IDLE;
				end
			end
			ofvd_pkg::ST_EMIT_E: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.kind = ofvd_pkg::KIND_ERROR;
					cmd.err = err_q;
					cmd.out_last = 1'b1;
					cmd.set_failed = 1'b1;
					state_d = ofvd_pkg::ST_IDLE;
				end
			end
			default: state_d = ofvd_pkg::ST_IDLE;
		endcase
	end

	`include "obj_face_vertex_dedup_fan_macros.svh"

	`OFVD_IMPLY(a_load_only_idle, cmd.load_in, state_q == ofvd_pkg::ST_IDLE)
	`OFVD_IMPLY(a_commit_with_out, cmd.commit, cmd.out_load && sts.out_free)
	`OFVD_NEXT(a_check_follows_load, cmd.load_in, state_q == ofvd_pkg::ST_CHECK)
endmodule

### design/ofvd_dp.sv
// Datapath of the vertex dedup block: index resolve, vertex table, face state, output beat.
module ofvd_dp (
	input logic clk,
	input logic arst_n,
	input logic [ofvd_pkg::IN_W-1:0] s_tdata,
	input logic s_tlast,
	output logic m_tvalid,
	input logic m_tready,
	output logic [ofvd_pkg::OUT_W-1:0] m_tdata,
	output logic [1:0] m_tuser,
	output logic m_tlast,
	input ofvd_pkg::cmd_t cmd,
	output ofvd_pkg::sts_t sts
);
	function automatic logic signed [25:0] resolve(input logic signed [24:0] raw,
			input logic [23:0] cnt, input logic present);
		logic signed [25:0] r;
		r = $signed({raw[24], raw});
		if (!present || raw == 25'sd0) return -26'sd1;
		if (raw > 25'sd0) return r - 26'sd1;
		return $signed({2'b00, cnt}) + r;
	endfunction

	logic signed [25:0] pos_q, tex_q, nrm_q;
	logic [23:0] pcnt_q, tcnt_q, ncnt_q;
	logic last_in_q;

	logic [ofvd_pkg::CW-1:0] vcount_q, issue_q;
	logic [ofvd_pkg::AW-1:0] rd_idx_s1, hit_idx_q, v;
	logic rd_vld_s1, found_q, failed_q;
	logic [23:0] rd_pos_s1;
	logic [49:0] rd_attr_s1;
	logic [23:0] mem_pos [ofvd_pkg::VTD];
	logic [49:0] mem_attr [ofvd_pkg::VTD];

	logic [1:0] corners_q;
	logic [ofvd_pkg::AW-1:0] first_q, prev_q, tri_b_q, v_q;

	logic m_tvalid_q, m_tlast_q;
	logic [1:0] m_tuser_q;
	logic [ofvd_pkg::OUT_W-1:0] m_tdata_q;
	logic [ofvd_pkg::OUT_W-1:0] beat_d;

	logic [23:0] key_pos;
	logic [49:0] key_attr;
	logic hit, out_free, full;

	assign key_pos = pos_q[23:0];
	assign key_attr = {tex_q[24:0], nrm_q[24:0]};
	assign hit = rd_vld_s1 && rd_pos_s1 == key_pos && rd_attr_s1 == key_attr;
	assign out_free = !m_tvalid_q || m_tready;
	assign full = vcount_q == ofvd_pkg::CW'(ofvd_pkg::VTD);
	assign v = found_q ? hit_idx_q : vcount_q[ofvd_pkg::AW-1:0];

	always_comb begin
		sts.failed = failed_q;
		sts.bad_pos = pos_q < 26'sd0 || pos_q >= $signed({2'b00, pcnt_q});
		sts.bad_attr = tex_q >= $signed({2'b00, tcnt_q}) || nrm_q >= $signed({2'b00, ncnt_q});
		sts.hit = hit;
		sts.miss = !rd_vld_s1 && issue_q == vcount_q;
		sts.full = full;
		sts.corners = corners_q;
		sts.last_in = last_in_q;
		sts.out_free = out_free;
	end

	// hold the resolved corner
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			pos_q <= resolve(s_tdata[24:0], s_tdata[100:77], 1'b1);
			tex_q <= resolve(s_tdata[50:26], s_tdata[124:101], s_tdata[25]);
			nrm_q <= resolve(s_tdata[76:52], s_tdata[148:125], s_tdata[51]);
			pcnt_q <= s_tdata[100:77];
			tcnt_q <= s_tdata[124:101];
			ncnt_q <= s_tdata[148:125];
			last_in_q <= s_tlast;
		end
	end

	// vertex table and fan corner registers
	always_ff @(posedge clk) begin
		if (cmd.commit && !found_q) begin
			mem_pos[vcount_q[ofvd_pkg::AW-1:0]] <= key_pos;
			mem_attr[vcount_q[ofvd_pkg::AW-1:0]] <= key_attr;
		end
		if (cmd.scan_run && issue_q < vcount_q) begin
			rd_pos_s1 <= mem_pos[issue_q[ofvd_pkg::AW-1:0]];
			rd_attr_s1 <= mem_attr[issue_q[ofvd_pkg::AW-1:0]];
			rd_idx_s1 <= issue_q[ofvd_pkg::AW-1:0];
		end
		if (cmd.scan_run && hit) begin
			hit_idx_q <= rd_idx_s1;
		end
		if (cmd.commit) begin
			v_q <= v;
			tri_b_q <= prev_q;
			prev_q <= v;
			if (corners_q == 2'd0) first_q <= v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
			issue_q <= '0;
			rd_vld_s1 <= 1'b0;
			found_q <= 1'b0;
			failed_q <= 1'b0;
			corners_q <= 2'd0;
		end else begin
			if (cmd.scan_start) begin
				issue_q <= '0;
				rd_vld_s1 <= 1'b0;
				found_q <= 1'b0;
			end else if (cmd.scan_run) begin
				if (issue_q < vcount_q) begin
					issue_q <= issue_q + 1'b1;
					rd_vld_s1 <= 1'b1;
				end else begin
					rd_vld_s1 <= 1'b0;
				end
				if (hit) found_q <= 1'b1;
			end
			if (cmd.commit) begin
				if (!found_q) vcount_q <= vcount_q + 1'b1;
				if (last_in_q) corners_q <= 2'd0;
				else if (corners_q != 2'd2) corners_q <= corners_q + 2'd1;
			end
			if (cmd.set_failed) failed_q <= 1'b1;
		end
	end

	// output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_comb begin
		beat_d = '0;
		unique case (cmd.kind)
			ofvd_pkg::KIND_VERTEX: begin
				beat_d[11:0] = ofvd_pkg::IDX_W'(v);
				beat_d[12] = !found_q;
				beat_d[36:13] = key_pos;
				beat_d[61:37] = tex_q[24:0];
				beat_d[86:62] = nrm_q[24:0];
			end
			ofvd_pkg::KIND_TRI: begin
				beat_d[98:87] = ofvd_pkg::IDX_W'(first_q);
				beat_d[110:99] = ofvd_pkg::IDX_W'(tri_b_q);
				beat_d[122:111] = ofvd_pkg::IDX_W'(v_q);
			end
			ofvd_pkg::KIND_ERROR: beat_d[125:123] = cmd.err;
			default: beat_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tuser_q <= cmd.kind;
			m_tlast_q <= cmd.out_last;
			m_tdata_q <= beat_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;
	assign m_tlast = m_tlast_q;

	`include "obj_face_vertex_dedup_fan_macros.svh"

	`OFVD_CHECK(a_count_bound, vcount_q <= ofvd_pkg::CW'(ofvd_pkg::VTD))
	`OFVD_IMPLY(a_no_write_full, cmd.commit && !found_q, !full)
	`OFVD_NEXT(a_failed_sticks, failed_q, failed_q)
	`OFVD_IMPLY(a_load_when_free, cmd.out_load, out_free)
endmodule

### design/obj_face_vertex_dedup_fan.sv
// Top level of the OBJ face corner welding and fan triangulation block.
// A corner is taken only while the block is idle. A bad position or attribute is found in the
// check state, which then moves to the error beat. Otherwise the lookup is a linear scan of
// the single-port vertex table memory, one entry per cycle: a corner that matches an entry
// gives its vertex beat once the scan reaches that entry, and a new corner only once every
// vertex already in the table has been read; a miss appends the corner at the end. A corner
// of a face from the third on gives a second beat with the fan triangle after the vertex
// beat, and a short face gives an error beat there instead. Each beat waits while the one
// before it is not taken on m_tready, and the next corner can be taken in the cycle after
// the last beat of the previous one is loaded. After any error beat every later corner is
// taken and dropped until reset. The table needs no clearing pass after reset.
module obj_face_vertex_dedup_fan (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// raw_position, has_tex, raw_tex, has_normal, raw_normal, position_count,
	// tex_count, normal_count, zero pad
	input logic [ofvd_pkg::IN_W-1:0] s_tdata,
	input logic s_tlast,
	output logic m_tvalid,
	input logic m_tready,
	// vertex_index, new_vertex, position_index, tex_index, normal_index,
	// corner_a, corner_b, corner_c, error_code, zero pad
	output logic [ofvd_pkg::OUT_W-1:0] m_tdata,
	// kind
	output logic [1:0] m_tuser,
	output logic m_tlast
);
	ofvd_pkg::cmd_t cmd;
	ofvd_pkg::sts_t sts;

	ofvd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts(sts),
		.cmd(cmd)
	);

	ofvd_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cmd(cmd),
		.sts(sts)
	);
endmodule
